@@ hdl/ccr_pkg.sv @@
// Package for the color contrast ratio checker: fixed-point formats, weights,
// grade codes and the sRGB linearization table built at elaboration.
// No dependencies.
package ccr_pkg;

    // Fixed-point precision
    localparam int LUM_FRAC_BITS   = 16;
    localparam int RATIO_FRAC_BITS = 8;

    // Linear channel and luminance, unsigned Q1.F
    localparam int LIN_W = LUM_FRAC_BITS + 1;
    localparam int LUM_W = LUM_FRAC_BITS + 1;

    // Weighted sum of three channels, weights in 1/10000
    localparam int WT_W   = 14;
    localparam int ACC_W  = LUM_FRAC_BITS + WT_W;
    localparam logic [WT_W-1:0] WT_RED   = WT_W'(2126);
    localparam logic [WT_W-1:0] WT_GREEN = WT_W'(7152);
    localparam logic [WT_W-1:0] WT_BLUE  = WT_W'(722);
    localparam int WT_SUM = 10000;

    // Divide by the weight sum: multiply by a truncated reciprocal, then one correction
    localparam int RECIP_S = ACC_W;
    localparam int RECIP_W = LUM_FRAC_BITS + 1;
    localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_S) / 64'd10000;
    localparam logic [RECIP_W-1:0] RECIP_M = RECIP_FULL[RECIP_W-1:0];
    localparam int PROD_W = ACC_W + RECIP_W;

    // Ratio (20*hi + 1) / (20*lo + 1), with 1.0 = 2^F
    localparam int NUM_W = LUM_FRAC_BITS + 5;
    localparam int Q_W   = RATIO_FRAC_BITS + 5;
    localparam int DVD_W = NUM_W + RATIO_FRAC_BITS;
    localparam int CMP_W = NUM_W + Q_W;
    localparam logic [NUM_W-1:0] LUM_ONE_N = NUM_W'(64'd1 << LUM_FRAC_BITS);
    localparam logic [NUM_W-1:0] OFFSET_SCALE = NUM_W'(20);

    // Ratio limits and grade thresholds
    localparam logic [Q_W-1:0] RATIO_MIN = Q_W'(64'd1 << RATIO_FRAC_BITS);
    localparam logic [Q_W-1:0] RATIO_MAX = Q_W'(64'd21 << RATIO_FRAC_BITS);
    localparam logic [Q_W-1:0] TH_7P0    = Q_W'(64'd7 << RATIO_FRAC_BITS);
    localparam logic [Q_W-1:0] TH_4P5    = Q_W'(64'd9 << (RATIO_FRAC_BITS - 1));
    localparam logic [Q_W-1:0] TH_3P0    = Q_W'(64'd3 << RATIO_FRAC_BITS);

    // Output contrast field width
    localparam int OUT_W = 13;

    typedef enum logic [1:0] {
        GRADE_FAIL = 2'd0,
        GRADE_AA   = 2'd1,
        GRADE_AAA  = 2'd2
    } grade_t;

    // Linearization table
    localparam int BIG_W        = 320;
    localparam int LIN_KNEE     = 10;
    localparam int LIN_KNEE_DIV = 16473;
    localparam int LIN_DEN      = 10761;
    localparam int SEARCH_STEPS = LUM_FRAC_BITS + 2;

    typedef logic [LIN_W-1:0] lin_t;
    typedef lin_t [255:0] lin_rom_t;

    // Exact floor of 2^F * ((40c + 561) / 10761)^2.4, linear segment below the knee
    function automatic lin_t lin_entry(input int unsigned c);
        logic [BIG_W-1:0] rhs;
        logic [BIG_W-1:0] den12;
        logic [BIG_W-1:0] trial;
        logic [63:0]      lo;
        logic [63:0]      hi;
        logic [63:0]      mid;
        logic [63:0]      lin_small;
        int unsigned      base;
        lin_t             result;
        base = 40 * c + 561;
        if (c <= LIN_KNEE) begin
            lin_small = (64'(5 * c) << LUM_FRAC_BITS) / 64'(LIN_KNEE_DIV);
            result = lin_small[LIN_W-1:0];
        end else begin
            rhs   = BIG_W'(1);
            den12 = BIG_W'(1);
            for (int k = 0; k < 12; k++) begin
                rhs   = rhs * BIG_W'(base);
                den12 = den12 * BIG_W'(LIN_DEN);
            end
            rhs = rhs << (5 * LUM_FRAC_BITS);
            lo  = 64'd0;
            hi  = 64'd1 << LUM_FRAC_BITS;
            for (int it = 0; it < SEARCH_STEPS; it++) begin
                if (lo < hi) begin
                    mid   = (lo + hi + 64'd1) >> 1;
                    trial = den12;
                    for (int k = 0; k < 5; k++) begin
                        trial = trial * BIG_W'(mid);
                    end
                    if (trial <= rhs) begin
                        lo = mid;
                    end else begin
                        hi = mid - 64'd1;
                    end
                end
            end
            result = lo[LIN_W-1:0];
        end
        return result;
    endfunction

    function automatic lin_rom_t build_lin_rom();
        lin_rom_t rom;
        for (int c = 0; c < 256; c++) begin
            rom[c] = lin_entry(c);
        end
        return rom;
    endfunction

    localparam lin_rom_t LIN_ROM = build_lin_rom();

endpackage

@@ hdl/ccr_lane.sv @@
// Luminance lane: three table lookups, weighted sum and divide by the weight sum.
// One lane per color; four pipeline stages with per-stage valid. Uses ccr_pkg.
module ccr_lane (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [7:0]                red,
    input  logic [7:0]                green,
    input  logic [7:0]                blue,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ccr_pkg::LUM_W-1:0] lum
);

    localparam int STAGES = 4;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   rdy;

    logic [ccr_pkg::LIN_W-1:0]   lin_r_reg, lin_g_reg, lin_b_reg;
    logic [ccr_pkg::LIN_W-1:0]   lin_r_next, lin_g_next, lin_b_next;
    logic [ccr_pkg::ACC_W-1:0]   acc_reg, acc_next;
    logic [ccr_pkg::ACC_W-1:0]   acc_d_reg;
    logic [ccr_pkg::PROD_W-1:0]  prod_reg, prod_next;
    logic [ccr_pkg::LUM_W-1:0]   lum_reg, lum_next;
    logic [ccr_pkg::LUM_W-1:0]   quo_est;
    logic [ccr_pkg::ACC_W-1:0]   rem_est;

    // Advance a stage when it is empty or the next one advances
    assign rdy[STAGES] = out_ready;
    for (genvar k = 0; k < STAGES; k++) begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[k-1];
                end
            end
        end
    end

    // Look up linear channels
    always_comb begin
        lin_r_next = ccr_pkg::LIN_ROM[red];
        lin_g_next = ccr_pkg::LIN_ROM[green];
        lin_b_next = ccr_pkg::LIN_ROM[blue];
    end

    // Form the weighted sum
    always_comb begin
        acc_next = ccr_pkg::ACC_W'(lin_r_reg) * ccr_pkg::ACC_W'(ccr_pkg::WT_RED)
                 + ccr_pkg::ACC_W'(lin_g_reg) * ccr_pkg::ACC_W'(ccr_pkg::WT_GREEN)
                 + ccr_pkg::ACC_W'(lin_b_reg) * ccr_pkg::ACC_W'(ccr_pkg::WT_BLUE);
    end

    // Multiply by the reciprocal of the weight sum
    always_comb begin
        prod_next = ccr_pkg::PROD_W'(acc_reg) * ccr_pkg::PROD_W'(ccr_pkg::RECIP_M);
    end

    // Correct the estimate, which may be one low
    always_comb begin
        quo_est  = prod_reg[ccr_pkg::RECIP_S +: ccr_pkg::LUM_W];
        rem_est  = acc_d_reg - ccr_pkg::ACC_W'(quo_est) * ccr_pkg::ACC_W'(ccr_pkg::WT_SUM);
        lum_next = quo_est;
        if (rem_est >= ccr_pkg::ACC_W'(ccr_pkg::WT_SUM)) begin
            lum_next = quo_est + ccr_pkg::LUM_W'(1);
        end
    end

    always_ff @(posedge clk) begin
        if (rdy[0]) begin
            lin_r_reg <= lin_r_next;
            lin_g_reg <= lin_g_next;
            lin_b_reg <= lin_b_next;
        end
        if (rdy[1]) begin
            acc_reg <= acc_next;
        end
        if (rdy[2]) begin
            prod_reg  <= prod_next;
            acc_d_reg <= acc_reg;
        end
        if (rdy[3]) begin
            lum_reg <= lum_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STAGES-1];
    assign lum       = lum_reg;

endmodule

@@ hdl/ccr_div.sv @@
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// Quotient is known to fit in Q_W bits. Uses ccr_pkg.
module ccr_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ccr_pkg::DVD_W-1:0] dividend,
    input  logic [ccr_pkg::NUM_W-1:0] divisor,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ccr_pkg::Q_W-1:0]   quotient
);

    localparam int STAGES = ccr_pkg::Q_W;

    logic [STAGES-1:0] valid_reg;
    logic [STAGES:0]   rdy;

    logic [ccr_pkg::DVD_W-1:0] rem_reg  [STAGES];
    logic [ccr_pkg::DVD_W-1:0] rem_next [STAGES];
    logic [ccr_pkg::NUM_W-1:0] den_reg  [STAGES];
    logic [ccr_pkg::NUM_W-1:0] den_next [STAGES];
    logic [ccr_pkg::Q_W-1:0]   quo_reg  [STAGES];
    logic [ccr_pkg::Q_W-1:0]   quo_next [STAGES];

    // Advance a stage when it is empty or the next one advances
    assign rdy[STAGES] = out_ready;
    for (genvar k = 0; k < STAGES; k++) begin : g_rdy
        assign rdy[k] = !valid_reg[k] || rdy[k+1];
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            valid_reg <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (rdy[k]) begin
                    valid_reg[k] <= (k == 0) ? in_valid : valid_reg[k-1];
                end
            end
        end
    end

    // Subtract the shifted divisor where it fits, most significant bit first
    for (genvar s = 0; s < STAGES; s++) begin : g_stage
        logic [ccr_pkg::DVD_W-1:0] rem_in;
        logic [ccr_pkg::NUM_W-1:0] den_in;
        logic [ccr_pkg::Q_W-1:0]   quo_in;
        logic [ccr_pkg::CMP_W-1:0] trial;
        logic [ccr_pkg::CMP_W-1:0] rem_ext;
        logic [ccr_pkg::CMP_W-1:0] diff;
        logic                      take;

        if (s == 0) begin : g_first
            assign rem_in = dividend;
            assign den_in = divisor;
            assign quo_in = '0;
        end else begin : g_rest
            assign rem_in = rem_reg[s-1];
            assign den_in = den_reg[s-1];
            assign quo_in = quo_reg[s-1];
        end

        assign trial   = ccr_pkg::CMP_W'(den_in) << (STAGES - 1 - s);
        assign rem_ext = ccr_pkg::CMP_W'(rem_in);
        assign take    = rem_ext >= trial;
        assign diff    = rem_ext - trial;

        always_comb begin
            rem_next[s] = take ? diff[ccr_pkg::DVD_W-1:0] : rem_in;
            den_next[s] = den_in;
            quo_next[s] = quo_in;
            if (take) begin
                quo_next[s] = quo_in | (ccr_pkg::Q_W'(1) << (STAGES - 1 - s));
            end
        end

        always_ff @(posedge clk) begin
            if (rdy[s]) begin
                rem_reg[s] <= rem_next[s];
                den_reg[s] <= den_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[STAGES-1];
    assign quotient  = quo_reg[STAGES-1];

endmodule

@@ hdl/ccr_merge.sv @@
// Merging stage: orders the two lane luminances, forms the ratio operands,
// divides through ccr_div, then clamps and grades. Uses ccr_pkg and ccr_div.
module ccr_merge (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [ccr_pkg::LUM_W-1:0] lum_a,
    input  logic [ccr_pkg::LUM_W-1:0] lum_b,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [ccr_pkg::Q_W-1:0]   ratio,
    output ccr_pkg::grade_t           normal_grade,
    output ccr_pkg::grade_t           large_grade
);

    logic                      prep_valid_reg;
    logic                      prep_rdy;
    logic [ccr_pkg::DVD_W-1:0] dvd_reg, dvd_next;
    logic [ccr_pkg::NUM_W-1:0] den_reg, den_next;
    logic [ccr_pkg::LUM_W-1:0] lum_hi, lum_lo;
    logic [ccr_pkg::NUM_W-1:0] num;

    logic                      div_in_ready;
    logic                      div_out_valid;
    logic [ccr_pkg::Q_W-1:0]   quo;

    logic                      out_valid_reg;
    logic                      out_rdy;
    logic [ccr_pkg::Q_W-1:0]   ratio_reg, ratio_next;
    ccr_pkg::grade_t           ng_reg, ng_next;
    ccr_pkg::grade_t           lg_reg, lg_next;

    assign out_rdy  = !out_valid_reg || out_ready;
    assign prep_rdy = !prep_valid_reg || div_in_ready;

    // Pick the lighter color and form both operands
    always_comb begin
        lum_hi   = (lum_a > lum_b) ? lum_a : lum_b;
        lum_lo   = (lum_a > lum_b) ? lum_b : lum_a;
        num      = ccr_pkg::NUM_W'(lum_hi) * ccr_pkg::OFFSET_SCALE + ccr_pkg::LUM_ONE_N;
        den_next = ccr_pkg::NUM_W'(lum_lo) * ccr_pkg::OFFSET_SCALE + ccr_pkg::LUM_ONE_N;
        dvd_next = ccr_pkg::DVD_W'(num) << ccr_pkg::RATIO_FRAC_BITS;
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            prep_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (prep_rdy) begin
                prep_valid_reg <= in_valid;
            end
            if (out_rdy) begin
                out_valid_reg <= div_out_valid;
            end
        end
    end

    always_ff @(posedge clk) begin
        if (prep_rdy) begin
            dvd_reg <= dvd_next;
            den_reg <= den_next;
        end
        if (out_rdy) begin
            ratio_reg <= ratio_next;
            ng_reg    <= ng_next;
            lg_reg    <= lg_next;
        end
    end

    ccr_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (prep_valid_reg),
        .in_ready  (div_in_ready),
        .dividend  (dvd_reg),
        .divisor   (den_reg),
        .out_valid (div_out_valid),
        .out_ready (out_rdy),
        .quotient  (quo)
    );

    // Clamp the ratio to 1.0 .. 21.0
    always_comb begin
        priority if (quo < ccr_pkg::RATIO_MIN) begin
            ratio_next = ccr_pkg::RATIO_MIN;
        end else if (quo > ccr_pkg::RATIO_MAX) begin
            ratio_next = ccr_pkg::RATIO_MAX;
        end else begin
            ratio_next = quo;
        end
    end

    // Grade normal and large text on the clamped ratio
    always_comb begin
        priority if (ratio_next >= ccr_pkg::TH_7P0) begin
            ng_next = ccr_pkg::GRADE_AAA;
        end else if (ratio_next >= ccr_pkg::TH_4P5) begin
            ng_next = ccr_pkg::GRADE_AA;
        end else begin
            ng_next = ccr_pkg::GRADE_FAIL;
        end

        priority if (ratio_next >= ccr_pkg::TH_4P5) begin
            lg_next = ccr_pkg::GRADE_AAA;
        end else if (ratio_next >= ccr_pkg::TH_3P0) begin
            lg_next = ccr_pkg::GRADE_AA;
        end else begin
            lg_next = ccr_pkg::GRADE_FAIL;
        end
    end

    assign in_ready     = prep_rdy;
    assign out_valid    = out_valid_reg;
    assign ratio        = ratio_reg;
    assign normal_grade = ng_reg;
    assign large_grade  = lg_reg;

endmodule

@@ hdl/color_contrast_ratio_checker_top.sv @@
// Top level of the color contrast ratio checker: two luminance lanes and the
// merging stage. Uses ccr_pkg, ccr_lane and ccr_merge.
//
// Usage
//   Input channel: in_valid / in_stall carry one item, a foreground and a
//   background 8-bit sRGB color. Output channel: out_valid / out_stall carry
//   one result item: contrast_q8 (Q5.8, 1.0 to 21.0), normal_grade and
//   large_grade (0 fail, 1 AA, 2 AAA). An item moves on an edge with valid
//   high and stall low.
//   Throughput: one item per cycle while out_stall is low.
//   Pipeline: 19 register stages (RATIO_FRAC_BITS + 11): four lane stages,
//   one operand stage, one divider stage per quotient bit (13) and one clamp
//   and grade stage.
//   Each pipeline stage has its own valid bit and moves on whenever the
//   stage after it is empty or moving, so bubbles close up behind a stalled
//   result. in_stall rises only once every stage holds an item.
//   Reset: clears all valid bits; no item is held, in_stall is low.
//   While out_stall is high the result item holds on the outputs.
module color_contrast_ratio_checker_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  fg_red,
    input  logic [7:0]  fg_green,
    input  logic [7:0]  fg_blue,
    input  logic [7:0]  bg_red,
    input  logic [7:0]  bg_green,
    input  logic [7:0]  bg_blue,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [12:0] contrast_q8,
    output logic [1:0]  normal_grade,
    output logic [1:0]  large_grade
);

    localparam int EXT_W = ccr_pkg::Q_W + ccr_pkg::OUT_W;

    logic                      rdy_fg, rdy_bg;
    logic                      lane_in_valid;
    logic                      vld_fg, vld_bg;
    logic                      lane_out_ready;
    logic [ccr_pkg::LUM_W-1:0] lum_fg, lum_bg;
    logic                      merge_in_ready;
    logic [ccr_pkg::Q_W-1:0]   ratio;
    logic [EXT_W-1:0]          ratio_ext;
    ccr_pkg::grade_t           ng, lg;

    // Hand an item to both lanes only when both take it
    assign in_stall       = !(rdy_fg && rdy_bg);
    assign lane_in_valid  = in_valid && !in_stall;
    assign lane_out_ready = merge_in_ready && vld_fg && vld_bg;

    ccr_lane u_lane_fg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_in_valid),
        .in_ready  (rdy_fg),
        .red       (fg_red),
        .green     (fg_green),
        .blue      (fg_blue),
        .out_valid (vld_fg),
        .out_ready (lane_out_ready),
        .lum       (lum_fg)
    );

    ccr_lane u_lane_bg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (lane_in_valid),
        .in_ready  (rdy_bg),
        .red       (bg_red),
        .green     (bg_green),
        .blue      (bg_blue),
        .out_valid (vld_bg),
        .out_ready (lane_out_ready),
        .lum       (lum_bg)
    );

    ccr_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (vld_fg && vld_bg),
        .in_ready     (merge_in_ready),
        .lum_a        (lum_fg),
        .lum_b        (lum_bg),
        .out_valid    (out_valid),
        .out_ready    (!out_stall),
        .ratio        (ratio),
        .normal_grade (ng),
        .large_grade  (lg)
    );

    // Fit the ratio to the output field
    assign ratio_ext    = EXT_W'(ratio);
    assign contrast_q8  = ratio_ext[ccr_pkg::OUT_W-1:0];
    assign normal_grade = ng;
    assign large_grade  = lg;

    // Input backpressure only when the pipeline is full up to the output
    a_stall_means_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled while output register empty");

    // The two lanes stay in lockstep
    a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (vld_fg == vld_bg) && (rdy_fg == rdy_bg))
        else $error("luminance lanes out of step");

    // AAA for normal text implies AAA for large text
    a_grade_aaa: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (ng == ccr_pkg::GRADE_AAA) |-> (lg == ccr_pkg::GRADE_AAA))
        else $error("normal grade AAA without large grade AAA");

    // A large-text fail implies a normal-text fail
    a_grade_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (lg == ccr_pkg::GRADE_FAIL) |-> (ng == ccr_pkg::GRADE_FAIL))
        else $error("large grade fail with normal grade pass");

endmodule
